// ===== sv/mwo_pkg.sv =====
`timescale 1ns / 1ps
package mwo_pkg;
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;
  localparam logic [2:0] LD_PHASE = 3'd0;
  localparam logic [2:0] LD_STEP  = 3'd1;
  localparam logic [2:0] LD_FADE1 = 3'd2;
  localparam logic [2:0] LD_FADE2 = 3'd3;
  localparam logic [2:0] LD_FADE3 = 3'd4;
  localparam logic [2:0] CFG_DIM   = 3'd0;
  localparam logic [2:0] CFG_CHIRP = 3'd1;
  localparam logic [2:0] CFG_F1    = 3'd2;
  localparam logic [2:0] CFG_F2    = 3'd3;
  localparam logic [2:0] CFG_F3    = 3'd4;
  localparam int VAL_W  = 40;
  localparam int FADE_W = 18;
  localparam logic signed [FADE_W-1:0] FADE_MAX = 18'sd131071;
  localparam logic signed [FADE_W-1:0] FADE_MIN = -18'sd131072;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  table_select;
    logic [9:0]  table_index;
    logic [15:0] table_word;
    logic [2:0]  load_target;
    logic [31:0] load_value;
  } in_item_t;

  // Multiply-accumulate command for the shared unit: a + floor((b-a)*f/2^16).
  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [FADE_W:0]  f;
  } mac_cmd_t;

  function automatic logic signed [FADE_W-1:0] fade_sat(
      input logic signed [FADE_W-1:0] f, input logic signed [FADE_W-1:0] s);
    logic signed [FADE_W:0] r;
    r = {f[FADE_W-1], f} + {s[FADE_W-1], s};
    if (r > FADE_MAX) return FADE_MAX;
    if (r < FADE_MIN) return FADE_MIN;
    return r[FADE_W-1:0];
  endfunction
endpackage

// ===== sv/mwo_if.sv =====
`timescale 1ns / 1ps
interface mwo_in_if;
  logic valid;
  logic ready;
  mwo_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mwo_out_if;
  logic valid;
  logic ready;
  logic [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/multidim_wavetable_oscillator_unit.sv =====
`timescale 1ns / 1ps
// Multi-dimensional wavetable oscillator.
// Items arrive on the in_ch channel, one per transfer: mode 0 asks for one sample,
// mode 1 writes a table word, mode 2 loads one word of running state. Only mode 0
// gives a result, which leaves on the out_ch channel as a saturated Q1.15 sample.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// With n = 2^dimensions tables, each table costs two reads on the single read port
// of the table memory and one pass through the shared multiplier, and each of the
// n - 1 crossfades one more multiplier pass. No new item is taken until a sample
// has reached the output register. A write passes through a write state before the
// next item is taken, while a load or an ignored item is handled in the idle state.
// The table memory has no reset; words must be written before they are read.
// Reset clears the phase, increment, fades and the configuration registers.
// When the receiver stalls, the finished sample waits in the output register while
// writes and loads go on; a further sample stops before its output stage, with the
// phase and fades unchanged, until the register has been emptied.
module multidim_wavetable_oscillator_unit #(
  parameter int LOG2_TABLE_SIZE = 10,
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  mwo_in_if.sink in_ch,
  mwo_out_if.source out_ch,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [31:0] cfg_data
);
  localparam int TL = LOG2_TABLE_SIZE;
  localparam int AW = TL + 3;
  localparam int VW = mwo_pkg::VAL_W;
  localparam int FW = mwo_pkg::FADE_W;
  localparam int DROP = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_MIX  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;

  logic [2:0] state;
  logic [1:0] dimensions;
  logic [31:0] chirp_step, phase_acc, phase_step;
  logic signed [FW-1:0] fade1_step, fade2_step, fade3_step;
  logic signed [FW-1:0] fade_one, fade_two, fade_three;
  logic [15:0] wave_store [0:(1<<AW)-1];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [2:0] k;          // table or mix slot
  logic [1:0] lvl;        // 0 interpolation, 1 fade3, 2 fade2, 3 fade1
  logic signed [VW-1:0] v [0:7];
  logic signed [VW-1:0] s0;
  mwo_pkg::in_item_t item;
  logic [15:0] sample;
  logic out_valid;
  logic out_load;
  mwo_pkg::mac_cmd_t cmd;
  logic mac_done;
  logic signed [VW-1:0] mac_res;

  logic [TL-1:0] i0, i1;
  logic [15:0] g;
  logic [3:0] ntab;
  logic signed [VW-1:0] sat;
  logic [15:0] sat16;

  assign i0 = phase_acc[31 -: TL];
  assign i1 = i0 + 1'b1;
  assign g = 16'(phase_acc >> (16 - TL));
  assign ntab = 4'd1 << dimensions;

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      wave_store[{item.table_select, TL'(item.table_index)}] <= item.table_word;
    end
    rd_data <= wave_store[rd_addr];
  end

  mwo_mac u_mac (.clk(clk), .rst(rst), .cmd(cmd), .done(mac_done), .result(mac_res));

  always_comb begin
    sat = v[0];
    if (sat > VW'(32767)) sat = VW'(32767);
    if (sat < -VW'(32768)) sat = -VW'(32768);
    sat16 = sat[15:0] & ~16'((17'd1 << DROP) - 17'd1);
  end

  // Read address follows the sequencer.
  always_comb begin
    rd_addr = {k, (state == S_RD0) ? i0 : i1};
  end

  // The output stage fires once the output register is empty or being emptied.
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.sample = sample;

  always_ff @(posedge clk) begin
    logic start_v;
    start_v = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dimensions <= 2'd0;
      chirp_step <= '0;
      fade1_step <= '0;
      fade2_step <= '0;
      fade3_step <= '0;
      phase_acc <= '0;
      phase_step <= '0;
      fade_one <= '0;
      fade_two <= '0;
      fade_three <= '0;
      k <= '0;
      lvl <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          mwo_pkg::CFG_DIM:   dimensions <= cfg_data[1:0];
          mwo_pkg::CFG_CHIRP: chirp_step <= cfg_data;
          mwo_pkg::CFG_F1:    fade1_step <= cfg_data[FW-1:0];
          mwo_pkg::CFG_F2:    fade2_step <= cfg_data[FW-1:0];
          mwo_pkg::CFG_F3:    fade3_step <= cfg_data[FW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            k <= '0;
            lvl <= '0;
            unique case (in_ch.data.mode)
              mwo_pkg::MODE_SAMPLE: state <= S_RD0;
              mwo_pkg::MODE_WRITE:  state <= S_WR;
              mwo_pkg::MODE_LOAD: begin
                unique case (in_ch.data.load_target)
                  mwo_pkg::LD_PHASE: phase_acc <= in_ch.data.load_value;
                  mwo_pkg::LD_STEP:  phase_step <= in_ch.data.load_value;
                  mwo_pkg::LD_FADE1: fade_one <= in_ch.data.load_value[FW-1:0];
                  mwo_pkg::LD_FADE2: fade_two <= in_ch.data.load_value[FW-1:0];
                  mwo_pkg::LD_FADE3: fade_three <= in_ch.data.load_value[FW-1:0];
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        S_WR: state <= S_IDLE;
        S_RD0: state <= S_RD1;
        S_RD1: begin
          // rd_data now holds the word at i0.
          s0 <= VW'($signed(rd_data));
          state <= S_WAIT;
        end
        S_WAIT: begin
          // rd_data holds the word at i1; interpolate as s0 + (s1-s0)*g/2^16.
          start_v = 1'b1;
          cmd.a <= s0;
          cmd.b <= VW'($signed(rd_data));
          cmd.f <= {1'b0, g, 2'b00} >> 2;
          state <= S_MIX;
        end
        S_MIX: begin
          if (mac_done) begin
            v[k] <= mac_res;
            if (lvl == 2'd0 && 4'(k) + 4'd1 < ntab) begin
              k <= k + 3'd1;
              state <= S_RD0;
            end else begin
              // Choose the next crossfade level with work to do.
              logic [1:0] nl;
              logic [2:0] nk;
              logic fin;
              nl = lvl;
              nk = k + 3'd1;
              fin = 1'b0;
              if (lvl == 2'd0) begin
                nk = '0;
                if (dimensions == 2'd3) nl = 2'd1;
                else if (dimensions == 2'd2) nl = 2'd2;
                else if (dimensions == 2'd1) nl = 2'd3;
                else fin = 1'b1;
              end else if (lvl == 2'd1 && nk == 3'd4) begin
                nl = 2'd2; nk = '0;
              end else if (lvl == 2'd2 && nk == 3'd2) begin
                nl = 2'd3; nk = '0;
              end else if (lvl == 2'd3) begin
                fin = 1'b1;
              end
              if (fin) begin
                state <= S_OUT;
              end else begin
                lvl <= nl;
                k <= nk;
                start_v = 1'b1;
                unique case (nl)
                  2'd1: begin
                    cmd.a <= (nk == k) ? mac_res : v[nk];
                    cmd.b <= (nk + 3'd4 == k) ? mac_res : v[nk + 3'd4];
                    cmd.f <= {fade_three[FW-1], fade_three};
                  end
                  2'd2: begin
                    cmd.a <= (nk == k) ? mac_res : v[nk];
                    cmd.b <= (nk + 3'd2 == k) ? mac_res : v[nk + 3'd2];
                    cmd.f <= {fade_two[FW-1], fade_two};
                  end
                  default: begin
                    cmd.a <= (k == 3'd0) ? mac_res : v[0];
                    cmd.b <= (k == 3'd1) ? mac_res : v[1];
                    cmd.f <= {fade_one[FW-1], fade_one};
                  end
                endcase
              end
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            sample <= sat16;
            if (dimensions >= 2'd1) begin
              logic signed [FW-1:0] f1;
              f1 = mwo_pkg::fade_sat(fade_one, fade1_step);
              if (dimensions == 2'd1 && f1[FW-1]) f1 = '0;
              fade_one <= f1;
            end
            if (dimensions >= 2'd2) fade_two <= mwo_pkg::fade_sat(fade_two, fade2_step);
            if (dimensions == 2'd3)
              fade_three <= mwo_pkg::fade_sat(fade_three, fade3_step);
            phase_acc <= phase_acc + phase_step;
            phase_step <= phase_step + chirp_step;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    cmd.start <= start_v;
  end
endmodule

// ===== sv/mwo_mac.sv =====
`timescale 1ns / 1ps
module mwo_mac (
  input  logic clk,
  input  logic rst,
  input  mwo_pkg::mac_cmd_t cmd,
  output logic done,
  output logic signed [mwo_pkg::VAL_W-1:0] result
);
  logic signed [mwo_pkg::VAL_W-1:0] a_q;
  logic signed [mwo_pkg::VAL_W-1:0] d_q;
  logic signed [mwo_pkg::FADE_W:0] f_q;
  logic signed [mwo_pkg::VAL_W+mwo_pkg::FADE_W:0] p_q;
  logic [1:0] stage;

  // Operands stay narrow in practice (about 22 by 19 bits).
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 2'd0;
    end else begin
      stage <= {stage[0], cmd.start};
    end
    if (cmd.start) begin
      a_q <= cmd.a;
      d_q <= cmd.b - cmd.a;
      f_q <= cmd.f;
    end
    if (stage[0]) begin
      p_q <= d_q * f_q;
    end
  end

  assign done = stage[1];
  assign result = a_q + mwo_pkg::VAL_W'(p_q >>> 16);
endmodule
